>>> design/lcdw_pkg.sv
// Shared types, codes and constant tables for the character LCD nibble bus writer.
// No dependencies; every module of the block imports this package.
package lcdw_pkg;

	// Input action codes
	typedef enum logic [1:0] {
		ACT_INIT = 2'd0,
		ACT_CMD  = 2'd1,
		ACT_DATA = 2'd2,
		ACT_POS  = 2'd3
	} action_t;

	// Wait kinds on the result side
	typedef enum logic [1:0] {
		WAIT_NONE  = 2'd0,
		WAIT_PULSE = 2'd1,
		WAIT_MS    = 2'd2
	} wait_kind_t;

	// Work kinds handed from front to back
	typedef enum logic [1:0] {
		JOB_INIT = 2'd0,
		JOB_BYTE = 2'd1,
		JOB_POS  = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic       rs;
		logic [7:0] data;
		logic       tail;
	} job_t;

	typedef struct packed {
		logic       select_data;
		logic [3:0] nibble;
		logic       enable;
		wait_kind_t wait_kind;
		logic [5:0] wait_ms;
		logic       last;
	} phase_t;

	// Job queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Phase counts per job kind
	localparam int          PHASE_W     = 6;
	localparam logic [5:0]  BYTE_LAST   = 6'd3;
	localparam logic [5:0]  POS_LAST    = 6'd4;
	localparam logic [5:0]  INIT_LAST   = 6'd34;
	localparam logic [5:0]  INIT_WAKE_LAST = 6'd6;
	localparam logic [5:0]  INIT_CMD_FIRST = 6'd7;
	localparam logic [5:0]  POWER_UP_MS = 6'd40;
	localparam logic [5:0]  FIRST_WAKE_MS = 6'd4;
	localparam logic [5:0]  ONE_MS      = 6'd1;
	localparam logic [3:0]  WAKE_NIBBLE = 4'h3;

	// Byte constants
	localparam logic [7:0] LEAD_LO     = 8'hCF;
	localparam logic [7:0] LEAD_HI     = 8'hDF;
	localparam logic [7:0] HIGH_HALF   = 8'h80;
	localparam logic [7:0] SHIFT_SPLIT = 8'h90;
	localparam logic [7:0] SHIFT_LOW   = 8'h70;
	localparam logic [7:0] SHIFT_HIGH  = 8'h30;
	localparam logic [7:0] DDRAM_SET   = 8'h80;
	localparam logic [2:0] ROW_COUNT   = 3'd4;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h40;
			2'd2:    b = 8'h14;
			default: b = 8'h54;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_cmd(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = 8'h28;
			3'd1:    c = 8'h28;
			3'd2:    c = 8'h0F;
			3'd3:    c = 8'h01;
			3'd4:    c = 8'h06;
			3'd5:    c = 8'h02;
			3'd6:    c = 8'h2A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [5:0] init_tail(input logic [2:0] i);
		logic [5:0] t;
		case (i)
			3'd3, 3'd5, 3'd6: t = 6'd2;
			default:          t = 6'd1;
		endcase
		return t;
	endfunction

	// One of the four phases of a byte: high nibble first, pulse then release.
	function automatic phase_t byte_phase(input logic rs, input logic [7:0] b,
			input logic [1:0] sub, input logic [5:0] tail_ms);
		phase_t p;
		p.select_data = rs;
		p.nibble      = sub[1] ? b[3:0] : b[7:4];
		p.enable      = ~sub[0];
		p.last        = 1'b0;
		if (!sub[0]) begin
			p.wait_kind = WAIT_PULSE;
			p.wait_ms   = '0;
		end else if (sub[1] && (tail_ms != '0)) begin
			p.wait_kind = WAIT_MS;
			p.wait_ms   = tail_ms;
		end else begin
			p.wait_kind = WAIT_NONE;
			p.wait_ms   = '0;
		end
		return p;
	endfunction

endpackage

>>> design/lcdw_front.sv
// Front end: accepts input items, holds the translate register and lead flag,
// and turns each item into a job for the queue. Depends on lcdw_pkg.
module lcdw_front import lcdw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] value,
	input  logic [5:0] column,
	input  logic [2:0] row,
	input  logic       queue_full,
	output logic       push,
	output job_t       push_job
);

	logic       translate_q;
	logic       lead_seen_q;
	logic       lead_nx;
	logic       has_job;
	logic       accept;
	logic [7:0] mapped;
	logic [7:0] addr;

	assign in_ready = ~queue_full;
	assign accept   = in_valid & in_ready;
	assign push     = accept & has_job;

	always_comb begin
		mapped = value;
		if (lead_seen_q && (value >= HIGH_HALF))
			mapped = (value < SHIFT_SPLIT) ? value + SHIFT_LOW : value + SHIFT_HIGH;
		addr = (row_base(row[1:0]) + {2'b00, column}) | DDRAM_SET;
	end

	always_comb begin
		push_job.kind = JOB_BYTE;
		push_job.rs   = 1'b0;
		push_job.data = value;
		push_job.tail = 1'b0;
		has_job       = 1'b1;
		lead_nx       = lead_seen_q;
		case (action)
			ACT_INIT: begin
				push_job.kind = JOB_INIT;
			end
			ACT_CMD: begin
				push_job.kind = JOB_BYTE;
			end
			ACT_DATA: begin
				push_job.rs = 1'b1;
				if (translate_q) begin
					if (value inside {[LEAD_LO:LEAD_HI]}) begin
						// lead byte: remember it, send nothing
						has_job = 1'b0;
						lead_nx = 1'b1;
					end else begin
						push_job.data = mapped;
						push_job.tail = 1'b1;
						lead_nx       = 1'b0;
					end
				end
			end
			ACT_POS: begin
				push_job.kind = JOB_POS;
				push_job.data = addr;
				push_job.tail = 1'b1;
				has_job       = (row < ROW_COUNT);
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			translate_q <= 1'b0;
			lead_seen_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				translate_q <= cfg_wr_data;
			if (accept)
				lead_seen_q <= lead_nx;
		end
	end

endmodule

>>> design/lcdw_fifo.sv
// Short job queue between front and back, register array with count.
// Depends on lcdw_pkg for the job type and depth.
module lcdw_fifo import lcdw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job queue read while empty");
`endif

endmodule

>>> design/lcdw_back.sv
// Back end: walks the head job through its pin phases, one per cycle while the output
// register is empty or being taken, into the output register. Depends on lcdw_pkg.
module lcdw_back import lcdw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       select_data,
	output logic [3:0] nibble,
	output logic       enable,
	output logic [1:0] wait_kind,
	output logic [5:0] wait_ms,
	output logic       last
);

	logic [PHASE_W-1:0] idx_q;
	logic [PHASE_W-1:0] init_j;
	logic [PHASE_W-1:0] pos_j;
	phase_t             ph;
	phase_t             out_q;
	logic               out_valid_q;
	logic               emit;

	assign emit = head_valid & (~out_valid_q | out_ready);
	assign pop  = emit & ph.last;

	always_comb begin
		init_j = idx_q - INIT_CMD_FIRST;
		pos_j  = idx_q - ONE_MS;
		ph     = byte_phase(head_job.rs, head_job.data, idx_q[1:0], {5'd0, head_job.tail});
		case (head_job.kind)
			JOB_BYTE: begin
				ph.last = (idx_q == BYTE_LAST);
			end
			JOB_POS: begin
				if (idx_q == '0) begin
					// lead phase: high nibble of the address, enable low, 1 ms
					ph.select_data = 1'b0;
					ph.nibble      = head_job.data[7:4];
					ph.enable      = 1'b0;
					ph.wait_kind   = WAIT_MS;
					ph.wait_ms     = ONE_MS;
				end else begin
					ph = byte_phase(1'b0, head_job.data, pos_j[1:0], {5'd0, head_job.tail});
				end
				ph.last = (idx_q == POS_LAST);
			end
			JOB_INIT: begin
				if (idx_q == '0) begin
					ph.select_data = 1'b0;
					ph.nibble      = '0;
					ph.enable      = 1'b0;
					ph.wait_kind   = WAIT_MS;
					ph.wait_ms     = POWER_UP_MS;
				end else if (idx_q <= INIT_WAKE_LAST) begin
					// three wake-up pulses on nibble 3
					ph.select_data = 1'b0;
					ph.nibble      = WAKE_NIBBLE;
					ph.enable      = idx_q[0];
					ph.wait_kind   = WAIT_MS;
					ph.wait_ms     = (idx_q == ONE_MS) ? FIRST_WAKE_MS : ONE_MS;
				end else begin
					ph = byte_phase(1'b0, init_cmd(init_j[4:2]), init_j[1:0],
						init_tail(init_j[4:2]));
				end
				ph.last = (idx_q == INIT_LAST);
			end
			default: begin
				ph.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				idx_q <= ph.last ? '0 : idx_q + 1'b1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign select_data = out_q.select_data;
	assign nibble      = out_q.nibble;
	assign enable      = out_q.enable;
	assign wait_kind   = out_q.wait_kind;
	assign wait_ms     = out_q.wait_ms;
	assign last        = out_q.last;

`ifndef NO_ASSERTIONS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ((head_job.kind == JOB_BYTE && idx_q <= BYTE_LAST) ||
			(head_job.kind == JOB_POS && idx_q <= POS_LAST) ||
			(head_job.kind == JOB_INIT && idx_q <= INIT_LAST)))
		else $error("phase index past end of job");

	a_ms_only_on_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.wait_kind != WAIT_MS) |-> (out_q.wait_ms == '0))
		else $error("wait_ms set on a phase without millisecond wait");
`endif

endmodule

>>> design/char_lcd_nibble_bus_writer_core.sv
// An accepted item goes through the job queue, then the back-end output register.
// Throughput: one phase per cycle while the output is not stalled; command and data
// bytes have 4 phases, set position 5, init 35; lead bytes and rows 4..7 take no back time.
// The input takes an item every cycle while the 4-entry job queue has room.
// Reset (arst_n low, asynchronous): translation off, lead flag clear, queue and output empty.
// Top level of the character LCD nibble bus writer; depends on lcdw_pkg, lcdw_front,
// lcdw_fifo and lcdw_back.
module char_lcd_nibble_bus_writer_core import lcdw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: translate_enable
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] value,
	input  logic [5:0] column,
	input  logic [2:0] row,
	// output channel, one beat per pin phase
	output logic       out_valid,
	input  logic       out_ready,
	output logic       select_data,
	output logic [3:0] nibble,
	output logic       enable,
	output logic [1:0] wait_kind,
	output logic [5:0] wait_ms,
	output logic       last
);

	// front to queue
	logic queue_full;
	logic push;
	job_t push_job;
	// queue to back
	logic head_valid;
	job_t head_job;
	logic pop;

	// Front: classify the item, apply Cyrillic mapping and the row base, drop
	// items that give no phases, push the rest as jobs.
	lcdw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.value       (value),
		.column      (column),
		.row         (row),
		.queue_full  (queue_full),
		.push        (push),
		.push_job    (push_job)
	);

	// Queue: lets the front keep taking items while the back is busy on a long job.
	lcdw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back: step through the phases of the head job; pop it with its last beat.
	lcdw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.select_data (select_data),
		.nibble      (nibble),
		.enable      (enable),
		.wait_kind   (wait_kind),
		.wait_ms     (wait_ms),
		.last        (last)
	);

endmodule
